>>> rtl/patch_normalized_cross_correlation_top_assert.svh
// assertion macros shared by the correlation block checkers
`ifndef PATCH_NORMALIZED_CROSS_CORRELATION_TOP_ASSERT_SVH
`define PATCH_NORMALIZED_CROSS_CORRELATION_TOP_ASSERT_SVH

// consequent must hold in the cycle after the antecedent, outside reset
`define NCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ncc check failed: next-cycle rule");

// consequent must hold in the same cycle as the antecedent, outside reset
`define NCC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ncc check failed: same-cycle rule");

// next-cycle rule that also holds while reset is applied
`define NCC_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ncc check failed: reset rule");

`endif

>>> rtl/ncc_pkg.sv
// types and constants of the patch correlation block
package ncc_pkg;

  localparam int MAX_PIXELS = 256;

  localparam int PIX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int SUM_W  = 16;
  localparam int SQ_W   = 24;
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int QUOT_W = 31;
  localparam int ROOT_W = 16;
  localparam int CORR_W = 16;

  localparam logic [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};

  typedef struct packed {
    logic [PIX_W-1:0] pixel_a;
    logic [PIX_W-1:0] pixel_b;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic                     degenerate;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_b;
    logic [SQ_W-1:0]  sum_aa;
    logic [SQ_W-1:0]  sum_bb;
    logic [SQ_W-1:0]  sum_ab;
  } sums_t;

endpackage

>>> rtl/ncc_accum.sv
// pair counter and running sums of a patch
module ncc_accum (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_en,
  input  logic             acc_clear,
  input  ncc_pkg::in_item_t pix,
  output ncc_pkg::sums_t   sums
);
  import ncc_pkg::*;

  sums_t sums_r, sums_nxt;
  logic [2*PIX_W-1:0] sq_a, sq_b, prod_ab;
  logic room;

  // small squares and cross product of one pair
  assign sq_a    = {{PIX_W{1'b0}}, pix.pixel_a} * {{PIX_W{1'b0}}, pix.pixel_a};
  assign sq_b    = {{PIX_W{1'b0}}, pix.pixel_b} * {{PIX_W{1'b0}}, pix.pixel_b};
  assign prod_ab = {{PIX_W{1'b0}}, pix.pixel_a} * {{PIX_W{1'b0}}, pix.pixel_b};
  assign room    = sums_r.count < CNT_W'(MAX_PIXELS);

  // pairs past the limit are dropped
  always_comb begin
    sums_nxt = sums_r;
    if (acc_clear) begin
      sums_nxt = '0;
    end else if (acc_en && room) begin
      sums_nxt.count  = sums_r.count + CNT_W'(1);
      sums_nxt.sum_a  = sums_r.sum_a + {{(SUM_W-PIX_W){1'b0}}, pix.pixel_a};
      sums_nxt.sum_b  = sums_r.sum_b + {{(SUM_W-PIX_W){1'b0}}, pix.pixel_b};
      sums_nxt.sum_aa = sums_r.sum_aa + {{(SQ_W-2*PIX_W){1'b0}}, sq_a};
      sums_nxt.sum_bb = sums_r.sum_bb + {{(SQ_W-2*PIX_W){1'b0}}, sq_b};
      sums_nxt.sum_ab = sums_r.sum_ab + {{(SQ_W-2*PIX_W){1'b0}}, prod_ab};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sums_r <= '0;
    end else begin
      sums_r <= sums_nxt;
    end
  end

  assign sums = sums_r;

endmodule

>>> rtl/ncc_mul.sv
// serial shift-and-add multiplier, one multiplier bit per cycle
module ncc_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ncc_pkg::MUL_W-1:0]  mcand,
  input  logic [ncc_pkg::MUL_W-1:0]  mplier,
  output logic [ncc_pkg::PROD_W-1:0] prod,
  output logic                       done
);
  import ncc_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] mc_r, mc_nxt;
  logic [MUL_W-1:0]  mp_r, mp_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;

  // stops as soon as the remaining multiplier bits are all zero
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      mc_nxt   = {{(PROD_W-MUL_W){1'b0}}, mcand};
      mp_nxt   = mplier;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (mp_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (mp_r[0]) begin
          acc_nxt = acc_r + mc_r;
        end
        mc_nxt = {mc_r[PROD_W-2:0], 1'b0};
        mp_nxt = {1'b0, mp_r[MUL_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    acc_r <= acc_nxt;
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

>>> rtl/ncc_div.sv
// restoring divider, one quotient bit per cycle, for cov^2 * 2^30 / var product
module ncc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ncc_pkg::PROD_W-1:0] num,
  input  logic [ncc_pkg::PROD_W-1:0] den,
  output logic [ncc_pkg::QUOT_W-1:0] quot,
  output logic                       done
);
  import ncc_pkg::*;

  localparam int CNT_DW = $clog2(QUOT_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_DW-1:0] cnt_r, cnt_nxt;
  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic              feed_r, feed_nxt;
  logic [QUOT_W-1:0] quot_r, quot_nxt;
  logic [PROD_W:0]   trial, diff;
  logic              ge;

  // the dividend is num followed by 30 zero bits: start from num >> 1
  assign trial = {rem_r, feed_r};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    feed_nxt = feed_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, num[PROD_W-1:1]};
      feed_nxt = num[0];
      quot_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
      quot_nxt = {quot_r[QUOT_W-2:0], ge};
      feed_nxt = 1'b0;
      cnt_nxt  = cnt_r + CNT_DW'(1);
      if (cnt_r == CNT_DW'(QUOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    feed_r <= feed_nxt;
    quot_r <= quot_nxt;
  end

  assign quot = quot_r;
  assign done = done_r;

endmodule

>>> rtl/ncc_sqrt.sv
// digit-by-digit integer square root, two radicand bits per cycle
module ncc_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ncc_pkg::QUOT_W-1:0] radicand,
  output logic [ncc_pkg::ROOT_W-1:0] root,
  output logic                       done
);
  import ncc_pkg::*;

  localparam int X_W    = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 4;
  localparam int CNT_SW = $clog2(ROOT_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_SW-1:0] cnt_r, cnt_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_sh, trial;
  logic              ge;

  // bring down the next radicand digit and try root*4+1
  assign rem_sh = {rem_r[REM_W-3:0], x_r[X_W-1:X_W-2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = {{(X_W-QUOT_W){1'b0}}, radicand};
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[ROOT_W-2:0], ge};
      x_nxt    = {x_r[X_W-3:0], 2'b00};
      cnt_nxt  = cnt_r + CNT_SW'(1);
      if (cnt_r == CNT_SW'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;
  assign done = done_r;

endmodule

>>> rtl/patch_normalized_cross_correlation_top.sv
// top level of the zero-mean normalized cross correlation block
//
// Input channel in_valid/in_ready/in_data carries one pixel pair per item, with
// a last flag on the final pair of a patch. Pairs are taken one per cycle while
// the block collects a patch; pairs beyond 256 are dropped but last still counts.
// Output channel out_valid/out_ready/out_data gives one item per patch: the
// Q1.15 correlation (truncated toward zero, +1.0 saturated to 32767) and a
// degenerate flag, set with a zero coefficient when either patch is flat.
// After the last item, one serial shift-add multiplier runs eight products in
// turn (one multiplier bit per cycle, stopping once the remaining bits are zero),
// then a restoring divider gives 31 quotient bits and a square root unit 16 root
// bits, one per cycle; a flat patch goes straight to the output after the
// variance terms and skips the last two products, the divider and the square
// root. in_ready stays low until the result has moved into the output register.
// The result sits in an output register, so a stalled receiver does not block
// the next patch's pairs; only the following result waits for out_ready.
// Synchronous active-low reset clears the sums, the sequencer and out_valid.
module patch_normalized_cross_correlation_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ncc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ncc_pkg::out_item_t out_data
);
  import ncc_pkg::*;

  typedef enum logic [3:0] {
    ST_ACC, ST_COV_N, ST_COV_S, ST_VA_N, ST_VA_S, ST_VB_N, ST_VB_S,
    ST_VAR_P, ST_COV_SQ, ST_DIV, ST_SQRT, ST_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic              issued_r, issued_nxt;
  logic [MUL_W-1:0]  first_r, first_nxt;
  logic [MUL_W:0]    cov_r, cov_nxt;
  logic [MUL_W:0]    va_r, va_nxt;
  logic [MUL_W:0]    vb_r, vb_nxt;
  logic [PROD_W-1:0] p_r, p_nxt;
  logic [PROD_W-1:0] c2_r, c2_nxt;
  logic [QUOT_W-1:0] quot_r, quot_nxt;
  logic [CORR_W-1:0] corr_r, corr_nxt;
  logic              degen_r, degen_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  sums_t             sums;
  logic              in_acc, acc_clear;
  logic              mul_start, mul_done, div_start, div_done, sqrt_start, sqrt_done;
  logic [MUL_W-1:0]  mcand, mplier, mag;
  logic [PROD_W-1:0] mul_prod;
  logic [QUOT_W-1:0] div_quot;
  logic [ROOT_W-1:0] root;
  logic [MUL_W:0]    diff, cov_abs;
  logic              is_mul_state, va_bad, vb_bad;

  assign in_ready  = (state_r == ST_ACC);
  assign in_acc    = in_valid && in_ready;
  assign acc_clear = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  ncc_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_en    (in_acc),
    .acc_clear (acc_clear),
    .pix       (in_data),
    .sums      (sums)
  );

  // operand selection for the shared multiplier
  always_comb begin
    is_mul_state = 1'b1;
    mcand        = '0;
    mplier       = '0;
    case (state_r)
      ST_COV_N: begin
        mcand  = {{(MUL_W-SQ_W){1'b0}}, sums.sum_ab};
        mplier = {{(MUL_W-CNT_W){1'b0}}, sums.count};
      end
      ST_COV_S: begin
        mcand  = {{(MUL_W-SUM_W){1'b0}}, sums.sum_a};
        mplier = {{(MUL_W-SUM_W){1'b0}}, sums.sum_b};
      end
      ST_VA_N: begin
        mcand  = {{(MUL_W-SQ_W){1'b0}}, sums.sum_aa};
        mplier = {{(MUL_W-CNT_W){1'b0}}, sums.count};
      end
      ST_VA_S: begin
        mcand  = {{(MUL_W-SUM_W){1'b0}}, sums.sum_a};
        mplier = {{(MUL_W-SUM_W){1'b0}}, sums.sum_a};
      end
      ST_VB_N: begin
        mcand  = {{(MUL_W-SQ_W){1'b0}}, sums.sum_bb};
        mplier = {{(MUL_W-CNT_W){1'b0}}, sums.count};
      end
      ST_VB_S: begin
        mcand  = {{(MUL_W-SUM_W){1'b0}}, sums.sum_b};
        mplier = {{(MUL_W-SUM_W){1'b0}}, sums.sum_b};
      end
      ST_VAR_P: begin
        mcand  = va_r[MUL_W-1:0];
        mplier = vb_r[MUL_W-1:0];
      end
      ST_COV_SQ: begin
        mcand  = mag;
        mplier = mag;
      end
      default: begin
        is_mul_state = 1'b0;
      end
    endcase
  end

  assign mul_start  = is_mul_state && !issued_r;
  assign div_start  = (state_r == ST_DIV) && !issued_r;
  assign sqrt_start = (state_r == ST_SQRT) && !issued_r;

  ncc_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mcand),
    .mplier (mplier),
    .prod   (mul_prod),
    .done   (mul_done)
  );

  ncc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (c2_r),
    .den   (p_r),
    .quot  (div_quot),
    .done  (div_done)
  );

  ncc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (quot_r),
    .root     (root),
    .done     (sqrt_done)
  );

  // difference of the two products of a term, and covariance magnitude
  assign diff    = {1'b0, first_r} - {1'b0, mul_prod[MUL_W-1:0]};
  assign cov_abs = cov_r[MUL_W] ? (~cov_r + {{MUL_W{1'b0}}, 1'b1}) : cov_r;
  assign mag     = cov_abs[MUL_W-1:0];
  assign va_bad  = va_r[MUL_W] || (va_r == '0);
  assign vb_bad  = diff[MUL_W] || (diff == '0);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    first_nxt     = first_r;
    cov_nxt       = cov_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    p_nxt         = p_r;
    c2_nxt        = c2_r;
    quot_nxt      = quot_r;
    corr_nxt      = corr_r;
    degen_nxt     = degen_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_ACC: begin
        if (in_acc && in_data.last) begin
          state_nxt = ST_COV_N;
        end
      end
      ST_COV_N, ST_COV_S, ST_VA_N, ST_VA_S, ST_VB_N, ST_VB_S, ST_VAR_P, ST_COV_SQ: begin
        if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (mul_done) begin
          issued_nxt = 1'b0;
          first_nxt  = mul_prod[MUL_W-1:0];
          case (state_r)
            ST_COV_N: state_nxt = ST_COV_S;
            ST_COV_S: begin
              cov_nxt   = diff;
              state_nxt = ST_VA_N;
            end
            ST_VA_N: state_nxt = ST_VA_S;
            ST_VA_S: begin
              va_nxt    = diff;
              state_nxt = ST_VB_N;
            end
            ST_VB_N: state_nxt = ST_VB_S;
            ST_VB_S: begin
              vb_nxt = diff;
              if (va_bad || vb_bad) begin
                degen_nxt = 1'b1;
                corr_nxt  = '0;
                state_nxt = ST_OUT;
              end else begin
                degen_nxt = 1'b0;
                state_nxt = ST_VAR_P;
              end
            end
            ST_VAR_P: begin
              p_nxt     = mul_prod;
              state_nxt = ST_COV_SQ;
            end
            default: begin
              c2_nxt    = mul_prod;
              state_nxt = ST_DIV;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (div_done) begin
          issued_nxt = 1'b0;
          quot_nxt   = div_quot;
          state_nxt  = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (sqrt_done) begin
          issued_nxt = 1'b0;
          // apply the sign, saturate +1.0
          if (cov_r[MUL_W]) begin
            corr_nxt = (~root) + {{(CORR_W-1){1'b0}}, 1'b1};
          end else if (root[ROOT_W-1]) begin
            corr_nxt = CORR_MAX;
          end else begin
            corr_nxt = root;
          end
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (acc_clear) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.correlation = corr_r;
          out_data_nxt.degenerate  = degen_r;
          state_nxt                = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
    first_r    <= first_nxt;
    cov_r      <= cov_nxt;
    va_r       <= va_nxt;
    vb_r       <= vb_nxt;
    p_r        <= p_nxt;
    c2_r       <= c2_nxt;
    quot_r     <= quot_nxt;
    corr_r     <= corr_nxt;
    degen_r    <= degen_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/ncc_checker.sv
// port-level checks of the correlation block, bound to its top level
`include "patch_normalized_cross_correlation_top_assert.svh"

module ncc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input ncc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ncc_pkg::out_item_t out_data
);
  import ncc_pkg::*;

  // a waiting result item holds
  `NCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // a flat patch always reports a zero coefficient
  `NCC_ASSERT_SAME(a_degen_zero, out_valid && out_data.degenerate, out_data.correlation == 0)

  // the last pair of a patch stops intake while the result is computed
  `NCC_ASSERT_NEXT(a_last_stalls, in_valid && in_ready && in_data.last, !in_ready)

  // reset leaves no result pending and the block ready for pairs
  `NCC_ASSERT_RESET(a_reset_idle, !rst_n, !out_valid && in_ready)

endmodule

bind patch_normalized_cross_correlation_top ncc_checker u_ncc_checker (.*);

>>> test/patch_normalized_cross_correlation_top_tb.sv
// testbench for the patch correlation block: predicted results checked against the output
module patch_normalized_cross_correlation_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ncc_pkg::*;

  typedef enum int unsigned {
    PATCH_RANDOM,
    PATCH_ALIKE,
    PATCH_MIRROR,
    PATCH_FLAT_A,
    PATCH_FLAT_B,
    PATCH_EXTREME
  } patch_kind_e;

  typedef enum int unsigned {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY,
    RDY_TOGGLE
  } ready_mode_e;

  localparam int unsigned RANDOM_PAIRS = 240;
  localparam int unsigned TAIL_CYCLES  = 300;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;

  // correlation results still owed by the block, oldest first
  out_item_t  corr_expected[$];

  // running sums of the patch being collected
  logic [CNT_W-1:0] pairs_kept;
  logic [SUM_W-1:0] acc_a;
  logic [SUM_W-1:0] acc_b;
  logic [SQ_W-1:0]  acc_aa;
  logic [SQ_W-1:0]  acc_bb;
  logic [SQ_W-1:0]  acc_ab;

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned degenerate_seen = 0;
  int unsigned saturated_seen = 0;
  int unsigned pairs_sent = 0;
  int unsigned patches_sent = 0;
  int unsigned lasts_sent = 0;

  // sender burst state
  int unsigned burst_left = 0;
  int unsigned gap_max = 0;

  ready_mode_e ready_mode = RDY_ALWAYS;
  int unsigned mode_left = 0;

  patch_normalized_cross_correlation_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("FAIL patch_normalized_cross_correlation_top");
    $finish;
  end

  // zncc of the current sums, exact integer search for the q1.15 magnitude
  function automatic out_item_t ncc_of_sums();
    out_item_t    res;
    longint       n, sa, sb, cov, va, vb, lo, hi, mid, corr;
    logic [63:0]  mag;
    logic [127:0] var_prod, rhs, lhs;
    n   = longint'(pairs_kept);
    sa  = longint'(acc_a);
    sb  = longint'(acc_b);
    cov = n * longint'(acc_ab) - sa * sb;
    va  = n * longint'(acc_aa) - sa * sa;
    vb  = n * longint'(acc_bb) - sb * sb;
    res = '0;
    if (va <= 0 || vb <= 0) begin
      res.degenerate = 1'b1;
    end else begin
      var_prod = 128'(va) * 128'(vb);
      mag = (cov < 0) ? 64'(-cov) : 64'(cov);
      rhs = (128'(mag) * 128'(mag)) << 30;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        lhs = 128'(mid * mid) * var_prod;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      corr = (cov < 0) ? -lo : lo;
      if (corr > 32767) corr = 32767;
      res.correlation = corr[CORR_W-1:0];
    end
    return res;
  endfunction

  function automatic void clear_sums();
    pairs_kept = '0;
    acc_a = '0;
    acc_b = '0;
    acc_aa = '0;
    acc_bb = '0;
    acc_ab = '0;
  endfunction

  // fold one accepted pair into the sums, predict on last
  function automatic void accumulate_pair(in_item_t item);
    logic [SQ_W-1:0] a, b;
    a = SQ_W'(item.pixel_a);
    b = SQ_W'(item.pixel_b);
    if (pairs_kept < MAX_PIXELS) begin
      pairs_kept = pairs_kept + 1'b1;
      acc_a  = acc_a + SUM_W'(item.pixel_a);
      acc_b  = acc_b + SUM_W'(item.pixel_b);
      acc_aa = acc_aa + a * a;
      acc_bb = acc_bb + b * b;
      acc_ab = acc_ab + a * b;
    end
    if (item.last) begin
      corr_expected = {corr_expected, ncc_of_sums()};
      clear_sums();
    end
  endfunction

  initial clear_sums();

  // track accepted pairs and check each result against the oldest prediction
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && in_valid && in_ready) accumulate_pair(in_data);
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.degenerate) degenerate_seen++;
      if (out_data.correlation == CORR_MAX) saturated_seen++;
      if (corr_expected.size() == 0) begin
        mismatches++;
        $error("unexpected result: correlation %0d degenerate %0b",
               out_data.correlation, out_data.degenerate);
      end else begin
        want = corr_expected.pop_front();
        if (out_data.correlation !== want.correlation) begin
          mismatches++;
          $error("correlation: expected %0d, got %0d",
                 want.correlation, out_data.correlation);
        end
        if (out_data.degenerate !== want.degenerate) begin
          mismatches++;
          $error("degenerate: expected %0b, got %0b",
                 want.degenerate, out_data.degenerate);
        end
      end
    end
  end

  // receiver stalls on a pattern that changes now and then
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      RDY_RARELY: out_ready <= ($urandom_range(0, 7) == 0);
      default:    out_ready <= ~out_ready;
    endcase
  end

  // send one pair, in bursts with random gaps between the bursts
  task automatic send_pair(input in_item_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pairs_sent++;
    if (item.last) lasts_sent++;
  endtask

  // one patch of the given length, content shaped by kind
  task automatic send_patch(input int unsigned len, input patch_kind_e kind);
    in_item_t    item;
    logic [7:0]  base_a, base_b;
    base_a = 8'($urandom_range(0, 255));
    base_b = 8'($urandom_range(0, 255));
    for (int unsigned i = 0; i < len; i++) begin
      item.pixel_a = 8'($urandom_range(0, 255));
      case (kind)
        PATCH_RANDOM: item.pixel_b = 8'($urandom_range(0, 255));
        PATCH_ALIKE:  item.pixel_b = item.pixel_a + 8'($urandom_range(0, 6)) - 8'd3;
        PATCH_MIRROR: item.pixel_b = ~item.pixel_a ^ 8'($urandom_range(0, 3));
        PATCH_FLAT_A: begin
          item.pixel_a = base_a;
          item.pixel_b = 8'($urandom_range(0, 255));
        end
        PATCH_FLAT_B: item.pixel_b = base_b;
        default: begin
          item.pixel_a = {8{1'($urandom_range(0, 1))}};
          item.pixel_b = {8{1'($urandom_range(0, 1))}};
        end
      endcase
      item.last = (i == len - 1);
      send_pair(item);
    end
    patches_sent++;
  endtask

  // hold the sender until every predicted result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_seen != lasts_sent) @(posedge clk);
  endtask

  // hand-picked patches: extremes, sign, flat patches, single pair
  task automatic test_directed();
    gap_max = 0;
    // single pair: no variance
    send_pair(in_item_t'{pixel_a: 8'd255, pixel_b: 8'd255, last: 1'b1});
    // perfect match saturates to +1
    send_pair(in_item_t'{pixel_a: 8'd0,   pixel_b: 8'd0,   last: 1'b0});
    send_pair(in_item_t'{pixel_a: 8'd255, pixel_b: 8'd255, last: 1'b1});
    // perfect inverse gives -1
    send_pair(in_item_t'{pixel_a: 8'd0,   pixel_b: 8'd255, last: 1'b0});
    send_pair(in_item_t'{pixel_a: 8'd255, pixel_b: 8'd0,   last: 1'b1});
    // first patch flat
    send_pair(in_item_t'{pixel_a: 8'd7,   pixel_b: 8'd1,   last: 1'b0});
    send_pair(in_item_t'{pixel_a: 8'd7,   pixel_b: 8'd200, last: 1'b0});
    send_pair(in_item_t'{pixel_a: 8'd7,   pixel_b: 8'd3,   last: 1'b1});
    // second patch flat
    send_pair(in_item_t'{pixel_a: 8'd0,   pixel_b: 8'd9,   last: 1'b0});
    send_pair(in_item_t'{pixel_a: 8'd128, pixel_b: 8'd9,   last: 1'b0});
    send_pair(in_item_t'{pixel_a: 8'd255, pixel_b: 8'd9,   last: 1'b1});
    // partial correlation
    send_pair(in_item_t'{pixel_a: 8'd0,   pixel_b: 8'd255, last: 1'b0});
    send_pair(in_item_t'{pixel_a: 8'd255, pixel_b: 8'd255, last: 1'b0});
    send_pair(in_item_t'{pixel_a: 8'd128, pixel_b: 8'd0,   last: 1'b1});
    // alternating bit patterns
    send_pair(in_item_t'{pixel_a: 8'h55,  pixel_b: 8'hAA,  last: 1'b0});
    send_pair(in_item_t'{pixel_a: 8'hAA,  pixel_b: 8'h55,  last: 1'b0});
    send_pair(in_item_t'{pixel_a: 8'h55,  pixel_b: 8'h55,  last: 1'b0});
    send_pair(in_item_t'{pixel_a: 8'hAA,  pixel_b: 8'hAA,  last: 1'b1});
  endtask

  // sender waits for the block to empty before going on
  task automatic test_drain_pause();
    gap_max = 4;
    send_patch(5, PATCH_ALIKE);
    wait_drained();
    send_patch(3, PATCH_RANDOM);
    wait_drained();
  endtask

  // a full-size patch and one with a pair past the limit
  task automatic test_overflow_patches();
    gap_max = 0;
    send_patch(MAX_PIXELS, PATCH_MIRROR);
    gap_max = 3;
    send_patch(MAX_PIXELS + 1, PATCH_ALIKE);
  endtask

  // random patches, mostly short, of every kind
  task automatic test_random_patches();
    int unsigned start, len, pick;
    start = pairs_sent;
    while (pairs_sent - start < RANDOM_PAIRS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) len = 1;
      else if (pick == 1) len = $urandom_range(40, 100);
      else len = $urandom_range(2, 20);
      gap_max = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 7) == 0) wait_drained();
      send_patch(len, patch_kind_e'($urandom_range(0, 5)));
    end
  endtask

  // test sequence
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_overflow_patches();
    test_random_patches();
    in_valid <= 1'b0;
    while (results_seen != lasts_sent) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d pairs in %0d patches, %0d results checked",
             pairs_sent, patches_sent, results_seen);
    $display("flat-patch results %0d, saturated +1 results %0d",
             degenerate_seen, saturated_seen);
    if (mismatches == 0 && corr_expected.size() == 0 && results_seen == lasts_sent) begin
      $display("PASS patch_normalized_cross_correlation_top");
    end else begin
      $display("FAIL patch_normalized_cross_correlation_top");
    end
    $finish;
  end

endmodule
